FILE: hw/rtl/bsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the banker's safety and request unit.
package bsr_pkg;

  localparam int CW = 8;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CLAIM   = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_UNSAFE  = 3'd3;
  localparam logic [2:0] ST_BADIDX  = 3'd4;
  localparam logic [2:0] ST_BADLOAD = 3'd5;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_TA    = 2'd1;
  localparam logic [1:0] CFG_TB    = 2'd2;
  localparam logic [1:0] CFG_TC    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] process;
    logic [7:0] amount_a;
    logic [7:0] amount_b;
    logic [7:0] amount_c;
    logic [7:0] claim_a;
    logic [7:0] claim_b;
    logic [7:0] claim_c;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] sequence_process;
    logic       sequence_valid;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic commit_load;
    logic apply_req;
    logic rollback;
    logic scan_start;
    logic scan_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad_index;
    logic bad_load;
    logic exceeds_need;
    logic exceeds_free;
    logic pass_end;
    logic progress;
    logic all_placed;
  } dp_stat_t;

endpackage

FILE: hw/rtl/bsr_datapath.sv
`timescale 1ns / 1ps
// Datapath: process rows, allocation sums, scan pool and safe sequence.
module bsr_datapath #(
  parameter int PROCESSES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bsr_pkg::dp_cmd_t  cmd,
  input  bsr_pkg::in_item_t in_item,
  input  logic [4:0]        process_count,
  input  logic [7:0]        total_a,
  input  logic [7:0]        total_b,
  input  logic [7:0]        total_c,
  input  logic [$clog2(PROCESSES+1)-1:0] emit_index,
  output bsr_pkg::dp_stat_t stat,
  output logic [3:0]        emit_process,
  output logic [$clog2(PROCESSES+1)-1:0] eff_n
);
  localparam int IW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int NW = $clog2(PROCESSES + 1);
  localparam int CW = bsr_pkg::CW;

  logic [CW-1:0] alloc [PROCESSES][3];
  logic [CW-1:0] need  [PROCESSES][3];
  logic [CW-1:0] asum [3];
  logic [CW:0]   pool [3];
  logic [PROCESSES-1:0] done;
  logic [IW-1:0] order [PROCESSES];
  logic [NW-1:0] placed;
  logic [NW-1:0] scan_i;
  logic          progress;
  bsr_pkg::in_item_t item;

  logic [CW-1:0] amt [3];
  logic [CW-1:0] clm [3];
  logic [CW-1:0] tot [3];
  logic [IW-1:0] pidx;
  logic [IW-1:0] sidx;
  logic          idx_bad;
  logic [CW:0]   freev [3];
  logic          fits;

  assign eff_n = ({1'b0, process_count} > 6'(PROCESSES)) ? NW'(PROCESSES) : NW'(process_count);
  assign amt[0] = item.amount_a;
  assign amt[1] = item.amount_b;
  assign amt[2] = item.amount_c;
  assign clm[0] = item.claim_a;
  assign clm[1] = item.claim_b;
  assign clm[2] = item.claim_c;
  assign tot[0] = total_a;
  assign tot[1] = total_b;
  assign tot[2] = total_c;
  assign idx_bad = ({1'b0, item.process} >= 5'(eff_n)) || (5'(item.process) >= 5'(PROCESSES));
  assign pidx = IW'(item.process);
  assign sidx = scan_i[IW-1:0];

  always_comb begin
    fits = 1'b1;
    stat = '0;
    for (int r = 0; r < 3; r++) begin
      freev[r] = (tot[r] > asum[r]) ? {1'b0, tot[r] - asum[r]} : '0;
      if (clm[r] < amt[r]) stat.bad_load = 1'b1;
      if (({1'b0, asum[r]} - {1'b0, alloc[pidx][r]} + {1'b0, amt[r]}) > {1'b0, tot[r]})
        stat.bad_load = 1'b1;
      if (amt[r] > need[pidx][r]) stat.exceeds_need = 1'b1;
      if ({1'b0, amt[r]} > freev[r]) stat.exceeds_free = 1'b1;
      if ({1'b0, need[sidx][r]} > pool[r]) fits = 1'b0;
    end
    stat.bad_index  = idx_bad;
    stat.pass_end   = (scan_i >= eff_n);
    stat.progress   = progress;
    stat.all_placed = (placed >= eff_n);
  end

  assign emit_process = 4'(order[emit_index[IW-1:0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROCESSES; i++) begin
        for (int r = 0; r < 3; r++) begin
          alloc[i][r] <= '0;
          need[i][r]  <= '0;
        end
      end
      for (int r = 0; r < 3; r++) asum[r] <= '0;
    end else begin
      if (cmd.commit_load) begin
        for (int r = 0; r < 3; r++) begin
          asum[r] <= asum[r] - alloc[pidx][r] + amt[r];
          alloc[pidx][r] <= amt[r];
          need[pidx][r]  <= clm[r] - amt[r];
        end
      end
      if (cmd.apply_req) begin
        for (int r = 0; r < 3; r++) begin
          asum[r] <= asum[r] + amt[r];
          alloc[pidx][r] <= alloc[pidx][r] + amt[r];
          need[pidx][r]  <= need[pidx][r] - amt[r];
        end
      end
      if (cmd.rollback) begin
        for (int r = 0; r < 3; r++) begin
          asum[r] <= asum[r] - amt[r];
          alloc[pidx][r] <= alloc[pidx][r] - amt[r];
          need[pidx][r]  <= need[pidx][r] + amt[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.scan_start) begin
      for (int r = 0; r < 3; r++) pool[r] <= freev[r];
      done <= '0;
      placed <= '0;
      scan_i <= '0;
      progress <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_i >= eff_n) begin
        scan_i <= '0;
        progress <= 1'b0;
      end else begin
        scan_i <= scan_i + 1'b1;
        if (!done[sidx] && fits) begin
          for (int r = 0; r < 3; r++) begin
            pool[r] <= ((pool[r] + {1'b0, alloc[sidx][r]}) > 9'(2**CW - 1)) ?
                       9'(2**CW - 1) : pool[r] + {1'b0, alloc[sidx][r]};
          end
          done[sidx] <= 1'b1;
          order[placed[IW-1:0]] <= sidx;
          placed <= placed + 1'b1;
          progress <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/bsr_controller.sv
`timescale 1ns / 1ps
// Controller: sequences item decode, scan passes and result delivery.
module bsr_controller #(
  parameter int PROCESSES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bsr_pkg::out_item_t out_item,
  output bsr_pkg::dp_cmd_t  cmd,
  input  bsr_pkg::dp_stat_t stat,
  input  logic [3:0]        emit_process,
  input  logic [$clog2(PROCESSES+1)-1:0] eff_n,
  output logic [$clog2(PROCESSES+1)-1:0] emit_index
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SEQ  = 3'd3;
  localparam logic [2:0] S_ONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] op;
  logic       is_req;
  logic [2:0] one_status;
  logic       out_free;
  // apply_req registers its update in the same edge scan_start would need,
  // so request scans start in the cycle after apply.
  logic       scan_pend;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.load_item = (state == S_IDLE) && in_valid;
    unique case (state)
      S_IDLE: if (in_valid && in_op != bsr_pkg::OP_NOP) state_next = S_DEC;
      S_DEC: begin
        if (op == bsr_pkg::OP_CHECK) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else if (stat.bad_index || stat.bad_load && op == bsr_pkg::OP_LOAD) begin
          state_next = S_ONE;
        end else if (op == bsr_pkg::OP_LOAD) begin
          cmd.commit_load = 1'b1;
          state_next = S_ONE;
        end else if (stat.exceeds_need || stat.exceeds_free) begin
          state_next = S_ONE;
        end else begin
          cmd.apply_req = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_pend) begin
          cmd.scan_start = 1'b1;
        end else if (stat.all_placed) begin
          state_next = S_SEQ;
        end else if (stat.pass_end && !stat.progress) begin
          cmd.rollback = is_req;
          state_next = S_ONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SEQ: if (out_free && (eff_n == '0 || emit_index + 1'b1 >= eff_n)) state_next = S_IDLE;
      S_ONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      emit_index <= '0;
      op <= '0;
      is_req <= 1'b0;
      one_status <= '0;
      scan_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid) begin
        op <= in_op;
        is_req <= (in_op == bsr_pkg::OP_REQUEST);
      end
      if (state == S_DEC) begin
        emit_index <= '0;
        scan_pend <= (state_next == S_SCAN) && op == bsr_pkg::OP_REQUEST;
        if (stat.bad_index && op != bsr_pkg::OP_CHECK) one_status <= bsr_pkg::ST_BADIDX;
        else if (op == bsr_pkg::OP_LOAD)
          one_status <= stat.bad_load ? bsr_pkg::ST_BADLOAD : bsr_pkg::ST_OK;
        else if (stat.exceeds_need) one_status <= bsr_pkg::ST_CLAIM;
        else one_status <= bsr_pkg::ST_WAIT;
      end
      if (state == S_SCAN && state_next == S_ONE) one_status <= bsr_pkg::ST_UNSAFE;
      if (state == S_SEQ && out_free) begin
        out_valid <= 1'b1;
        out_item.status <= bsr_pkg::ST_OK;
        if (eff_n == '0) begin
          out_item.sequence_process <= '0;
          out_item.sequence_valid <= 1'b0;
          out_item.last <= 1'b1;
        end else begin
          out_item.sequence_process <= emit_process;
          out_item.sequence_valid <= 1'b1;
          out_item.last <= (emit_index + 1'b1 >= eff_n);
        end
        emit_index <= emit_index + 1'b1;
      end
      if (state == S_ONE && out_free) begin
        out_valid <= 1'b1;
        out_item.status <= one_status;
        out_item.sequence_process <= '0;
        out_item.sequence_valid <= 1'b0;
        out_item.last <= 1'b1;
      end
      if (scan_pend) scan_pend <= 1'b0;
    end
  end
endmodule

FILE: hw/rtl/bankers_safety_and_request_unit.sv
`timescale 1ns / 1ps
// Top level of the banker's safety and request unit.
// Usage:
//   in_valid/in_stall carry one in_item (load, request or check).
//   out_valid/out_stall carry results; the last result of an item has last set.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Operation:
//   One item at a time. Loads and requests refused at decode skip the scan.
//   Checks and requests that pass decode run the safety scan: each pass visits
//   process_count rows, capped at PROCESSES, one row per cycle, up to that many
//   passes, a rate set by the single row comparator of the scan loop; the safe
//   sequence then leaves at one result per cycle while out_stall is low.
// Reset:
//   rst clears all rows and sums and loads count 5 and totals 10, 5, 7.
// Stall:
//   A stalled result holds; the next result waits behind it (the scan does not), and
//   in_stall stays high until the item's last result enters the output register.
module bankers_safety_and_request_unit #(
  parameter int PROCESSES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bsr_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  localparam int NW = $clog2(PROCESSES + 1);

  logic [4:0] process_count;
  logic [7:0] total_a, total_b, total_c;
  bsr_pkg::dp_cmd_t  cmd;
  bsr_pkg::dp_stat_t stat;
  logic [3:0]  emit_process;
  logic [NW-1:0] eff_n, emit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= 5'd5;
      total_a <= 8'd10;
      total_b <= 8'd5;
      total_c <= 8'd7;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsr_pkg::CFG_COUNT: process_count <= cfg_data[4:0];
        bsr_pkg::CFG_TA:    total_a <= cfg_data;
        bsr_pkg::CFG_TB:    total_b <= cfg_data;
        bsr_pkg::CFG_TC:    total_c <= cfg_data;
        default: ;
      endcase
    end
  end

  bsr_datapath #(.PROCESSES(PROCESSES)) u_dp (
    .clk, .rst, .cmd, .in_item, .process_count, .total_a, .total_b, .total_c,
    .emit_index, .stat, .emit_process, .eff_n
  );

  bsr_controller #(.PROCESSES(PROCESSES)) u_ctl (
    .clk, .rst, .in_valid, .in_op(in_item.operation), .in_stall, .out_valid,
    .out_stall, .out_item, .cmd, .stat, .emit_process, .eff_n, .emit_index
  );
endmodule

FILE: hw/rtl/bsr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the banker's unit, bound to the top level.
module bsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bsr_pkg::out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");
  a_seq_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sequence_valid |-> out_item.status == bsr_pkg::ST_OK)
    else $error("sequence entry with error status");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != bsr_pkg::ST_OK |-> out_item.last)
    else $error("error result not last");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("input taken mid sequence");
endmodule

bind bankers_safety_and_request_unit bsr_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_item
);

FILE: tb/bankers_safety_and_request_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the banker's safety and request unit.
module bankers_safety_and_request_unit_tb;

  localparam int NPROC = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bsr_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bsr_pkg::out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = bsr_pkg::CFG_COUNT;
  logic [7:0] cfg_data = '0;

  always #4 clk = ~clk;

  bankers_safety_and_request_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0] alloc_m [NPROC][3];
  logic [7:0] need_m [NPROC][3];
  int unsigned sum_m [3];
  int unsigned count_m;
  int unsigned total_m [3];
  bsr_pkg::out_item_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;

  task automatic reset_model();
    for (int i = 0; i < NPROC; i++)
      for (int r = 0; r < 3; r++) begin
        alloc_m[i][r] = '0;
        need_m[i][r] = '0;
      end
    for (int r = 0; r < 3; r++) sum_m[r] = 0;
    count_m = 5;
    total_m[0] = 10;
    total_m[1] = 5;
    total_m[2] = 7;
  endtask

  function automatic int unsigned free_amount(int r);
    return total_m[r] > sum_m[r] ? total_m[r] - sum_m[r] : 0;
  endfunction

  function automatic bit safety_scan(int unsigned n, ref int unsigned order[NPROC]);
    int unsigned pool [3];
    bit done [NPROC];
    int unsigned placed;
    bit progress;
    bit fits;
    placed = 0;
    for (int i = 0; i < NPROC; i++) done[i] = 1'b0;
    for (int r = 0; r < 3; r++) pool[r] = free_amount(r);
    while (placed < n) begin
      progress = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int r = 0; r < 3; r++) if (need_m[i][r] > pool[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < 3; r++) pool[r] += alloc_m[i][r];
            order[placed] = i;
            placed++;
            done[i] = 1'b1;
            progress = 1'b1;
          end
        end
      end
      if (!progress) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bsr_pkg::out_item_t single_result(logic [2:0] st);
    bsr_pkg::out_item_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    return o;
  endfunction

  task automatic push_scan(int unsigned n);
    int unsigned order [NPROC];
    bsr_pkg::out_item_t o;
    if (!safety_scan(n, order)) pending_results.push_back(single_result(bsr_pkg::ST_UNSAFE));
    else if (n == 0) pending_results.push_back(single_result(bsr_pkg::ST_OK));
    else
      for (int k = 0; k < n; k++) begin
        o = '0;
        o.sequence_process = order[k][3:0];
        o.sequence_valid = 1'b1;
        o.last = (k + 1 == n);
        pending_results.push_back(o);
      end
  endtask

  task automatic predict_item(bsr_pkg::in_item_t it);
    int unsigned n;
    int unsigned p;
    int unsigned amt [3];
    int unsigned clm [3];
    bit bad;
    n = count_m > NPROC ? NPROC : count_m;
    p = it.process;
    amt[0] = it.amount_a; amt[1] = it.amount_b; amt[2] = it.amount_c;
    clm[0] = it.claim_a; clm[1] = it.claim_b; clm[2] = it.claim_c;
    if (it.operation == bsr_pkg::OP_CHECK) begin
      push_scan(n);
      return;
    end
    if (it.operation != bsr_pkg::OP_LOAD && it.operation != bsr_pkg::OP_REQUEST) return;
    if (p >= n) begin
      pending_results.push_back(single_result(bsr_pkg::ST_BADIDX));
      return;
    end
    if (it.operation == bsr_pkg::OP_LOAD) begin
      bad = 1'b0;
      for (int r = 0; r < 3; r++) begin
        if (clm[r] < amt[r]) bad = 1'b1;
        if (sum_m[r] - alloc_m[p][r] + amt[r] > total_m[r]) bad = 1'b1;
      end
      if (bad) begin
        pending_results.push_back(single_result(bsr_pkg::ST_BADLOAD));
        return;
      end
      for (int r = 0; r < 3; r++) begin
        sum_m[r] = sum_m[r] - alloc_m[p][r] + amt[r];
        alloc_m[p][r] = 8'(amt[r]);
        need_m[p][r] = 8'(clm[r] - amt[r]);
      end
      pending_results.push_back(single_result(bsr_pkg::ST_OK));
      return;
    end
    for (int r = 0; r < 3; r++)
      if (amt[r] > need_m[p][r]) begin
        pending_results.push_back(single_result(bsr_pkg::ST_CLAIM));
        return;
      end
    for (int r = 0; r < 3; r++)
      if (amt[r] > free_amount(r)) begin
        pending_results.push_back(single_result(bsr_pkg::ST_WAIT));
        return;
      end
    for (int r = 0; r < 3; r++) begin
      sum_m[r] += amt[r];
      alloc_m[p][r] += 8'(amt[r]);
      need_m[p][r] -= 8'(amt[r]);
    end
    begin
      int unsigned order [NPROC];
      if (safety_scan(n, order)) begin
        push_scan(n);
        return;
      end
    end
    for (int r = 0; r < 3; r++) begin
      sum_m[r] -= amt[r];
      alloc_m[p][r] -= 8'(amt[r]);
      need_m[p][r] += 8'(amt[r]);
    end
    pending_results.push_back(single_result(bsr_pkg::ST_UNSAFE));
  endtask

  // receiver: stall pattern, checking
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result exp none act %p", $time, out_item);
          errors++;
        end else begin
          bsr_pkg::out_item_t e;
          e = pending_results.pop_front();
          if (out_item.status !== e.status || out_item.last !== e.last ||
              out_item.sequence_process !== e.sequence_process ||
              out_item.sequence_valid !== e.sequence_valid) begin
            $display("%0t: result mismatch exp %p act %p", $time, e, out_item);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  task automatic send_item(bsr_pkg::in_item_t it, bit check_fixed, bsr_pkg::out_item_t fixed);
    while (burst_left == 0) begin
      if ($urandom_range(0, 1)) begin
        @(posedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(posedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    predict_item(it);
    if (check_fixed && pending_results.size() > 0 &&
        pending_results[pending_results.size() - 1] !== fixed) begin
      $display("%0t: predictor disagrees exp %p act %p", $time, fixed,
               pending_results[pending_results.size() - 1]);
      errors++;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bsr_pkg::CFG_COUNT: count_m = val[4:0];
      bsr_pkg::CFG_TA: total_m[0] = val;
      bsr_pkg::CFG_TB: total_m[1] = val;
      default: total_m[2] = val;
    endcase
  endtask

  function automatic bsr_pkg::in_item_t mk(logic [1:0] op, logic [3:0] p, logic [7:0] a,
                                           logic [7:0] b, logic [7:0] c, logic [7:0] ca,
                                           logic [7:0] cb, logic [7:0] cc);
    bsr_pkg::in_item_t it;
    it.operation = op; it.process = p;
    it.amount_a = a; it.amount_b = b; it.amount_c = c;
    it.claim_a = ca; it.claim_b = cb; it.claim_c = cc;
    return it;
  endfunction

  typedef struct {
    bsr_pkg::in_item_t item;
    bit fixed_valid;
    logic [2:0] fixed_status;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    bsr_pkg::in_item_t it;
    int unsigned n_eff;
    reset_model();
    directed.push_back('{mk(bsr_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0), 0, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 5, 0, 0, 0, 0, 0, 0), 1, bsr_pkg::ST_BADIDX});
    directed.push_back('{mk(bsr_pkg::OP_REQUEST, 15, 0, 0, 0, 0, 0, 0), 1, bsr_pkg::ST_BADIDX});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 0, 2, 1, 0, 1, 1, 1), 1, bsr_pkg::ST_BADLOAD});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 0, 11, 0, 0, 11, 0, 0), 1, bsr_pkg::ST_BADLOAD});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 0, 0, 1, 0, 7, 5, 3), 1, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 1, 2, 0, 0, 3, 2, 2), 1, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 2, 3, 0, 2, 9, 0, 2), 1, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 3, 2, 1, 1, 2, 2, 2), 1, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 4, 0, 0, 2, 4, 3, 3), 1, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_CHECK, 9, 0, 0, 0, 0, 0, 0), 0, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_REQUEST, 1, 1, 0, 2, 0, 0, 0), 0, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_REQUEST, 1, 9, 0, 0, 0, 0, 0), 1, bsr_pkg::ST_CLAIM});
    directed.push_back('{mk(bsr_pkg::OP_REQUEST, 4, 3, 3, 0, 0, 0, 0), 0, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_REQUEST, 0, 0, 2, 0, 0, 0, 0), 0, bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_NOP, 0, 255, 255, 255, 255, 255, 255), 0,
                         bsr_pkg::ST_OK});
    directed.push_back('{mk(bsr_pkg::OP_LOAD, 0, 255, 255, 255, 255, 255, 255), 1,
                         bsr_pkg::ST_BADLOAD});
    directed.push_back('{mk(bsr_pkg::OP_CHECK, 15, 255, 255, 255, 255, 255, 255), 0,
                         bsr_pkg::ST_OK});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_item(directed[i].item, directed[i].fixed_valid,
                                    single_result(directed[i].fixed_status));
    drain();

    // phase settings: count extremes and total extremes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(bsr_pkg::CFG_COUNT, 8'd0); write_reg(bsr_pkg::CFG_TA, 8'd0);
                 write_reg(bsr_pkg::CFG_TB, 8'd255); write_reg(bsr_pkg::CFG_TC, 8'd1); end
        1: begin write_reg(bsr_pkg::CFG_COUNT, 8'd16); write_reg(bsr_pkg::CFG_TA, 8'd255);
                 write_reg(bsr_pkg::CFG_TB, 8'd255); write_reg(bsr_pkg::CFG_TC, 8'd255); end
        2: begin write_reg(bsr_pkg::CFG_COUNT, 8'd31); write_reg(bsr_pkg::CFG_TA, 8'd40);
                 write_reg(bsr_pkg::CFG_TB, 8'd30); write_reg(bsr_pkg::CFG_TC, 8'd20); end
        3: begin write_reg(bsr_pkg::CFG_COUNT, 8'd1); write_reg(bsr_pkg::CFG_TA, 8'd3); end
        4: begin write_reg(bsr_pkg::CFG_COUNT, 8'd8); write_reg(bsr_pkg::CFG_TA, 8'd20);
                 write_reg(bsr_pkg::CFG_TB, 8'd12); write_reg(bsr_pkg::CFG_TC, 8'd15); end
        default: begin write_reg(bsr_pkg::CFG_COUNT, 8'($urandom_range(2, 16)));
                 write_reg(bsr_pkg::CFG_TA, 8'd0); write_reg(bsr_pkg::CFG_TB, 8'd2);
                 write_reg(bsr_pkg::CFG_TC, 8'd0); end
      endcase
      n_eff = count_m > NPROC ? NPROC : (count_m == 0 ? 1 : count_m);
      for (int k = 0; k < 35; k++) begin
        it = '0;
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            it.operation = bsr_pkg::OP_LOAD;
            it.process = 4'($urandom_range(0, n_eff - 1));
            it.amount_a = 8'($urandom_range(0, 6)); it.amount_b = 8'($urandom_range(0, 6));
            it.amount_c = 8'($urandom_range(0, 6));
            it.claim_a = 8'(it.amount_a + $urandom_range(0, 8));
            it.claim_b = 8'(it.amount_b + $urandom_range(0, 8));
            it.claim_c = 8'(it.amount_c + $urandom_range(0, 8));
          end
          3, 4, 5: begin
            it.operation = bsr_pkg::OP_REQUEST;
            it.process = 4'($urandom_range(0, n_eff - 1));
            it.amount_a = 8'($urandom_range(0, 3)); it.amount_b = 8'($urandom_range(0, 3));
            it.amount_c = 8'($urandom_range(0, 3));
            it.claim_a = 8'($urandom); it.claim_b = 8'($urandom); it.claim_c = 8'($urandom);
          end
          6, 7: begin
            it = $bits(bsr_pkg::in_item_t)'($urandom);
            it.operation = bsr_pkg::OP_CHECK;
          end
          default: begin
            it = $bits(bsr_pkg::in_item_t)'({$urandom, $urandom});
          end
        endcase
        send_item(it, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
